>>> rtl/acls_pkg.sv
`timescale 1ns / 1ps

package acls_pkg;

  // Fixed field widths of a transaction
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int NZ_W     = 11;
  localparam int BYTE_W   = 12;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [MAG_W-1:0]    mag_t;

endpackage

>>> rtl/acls_div.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module acls_div #(
  parameter int DW = 27,
  parameter int NW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [NW-1:0]    rem;
  logic [NW-1:0]    dvsr;
  logic [CNT_W-1:0] cnt;
  logic [NW:0]      rem_shift;
  logic [NW:0]      rem_diff;

  // Trial subtraction for the current bit
  assign rem_shift = {rem, quotient[DW-1]};
  assign rem_diff  = rem_shift - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        dvsr     <= divisor;
        rem      <= '0;
        cnt      <= CNT_W'(DW);
      end else if (cnt != '0) begin
        if (!rem_diff[NW]) begin
          rem      <= rem_diff[NW-1:0];
          quotient <= {quotient[DW-2:0], 1'b1};
        end else begin
          rem      <= rem_shift[NW-1:0];
          quotient <= {quotient[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/audio_capture_level_stats_unit.sv
`timescale 1ns / 1ps

// Audio level meter with DC removal. Samples of a frame are taken one per
// cycle (start high while busy is low), written into an on-chip sample buffer
// of MAX_SAMPLES entries and summed; samples past capacity are dropped and
// flagged. The transaction with last_sample set closes the frame and raises
// busy while a bit-serial divider produces the DC offset, the buffer is
// read back once through its single read port, one entry per cycle, and
// the divider runs again for the mean magnitude. The result is shown for
// exactly one cycle with result_valid and must be captured then; busy is
// already low in that cycle, so the next frame may begin at once.
module audio_capture_level_stats_unit
  import acls_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last_sample,
  output logic                       result_valid,
  output logic [MAG_W-1:0]           peak_magnitude,
  output logic [MAG_W-1:0]           mean_magnitude,
  output logic [NZ_W-1:0]            nonzero_count,
  output logic [BYTE_W-1:0]          byte_count,
  output logic signed [SAMPLE_W-1:0] frame_offset,
  output logic                       overflow
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SW = SAMPLE_W + CW;
  localparam int MW = MAG_W + CW;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DC_START,
    S_DC_WAIT,
    S_SCAN,
    S_MEAN_START,
    S_MEAN_WAIT
  } state_t;

  state_t state;

  logic [CW-1:0]        count;
  logic signed [SW-1:0] run_sum;
  logic                 dropped;
  logic                 accept;
  logic                 has_room;

  sample_t              store [MAX_SAMPLES];
  sample_t              rdata;
  logic [CW-1:0]        rd_idx;
  logic                 rd_valid;
  logic                 mag_valid;
  mag_t                 mag;
  sample_t              dc;

  mag_t                 peak;
  logic [MW-1:0]        mag_sum;
  logic [CW-1:0]        nz;

  logic                 div_start;
  logic                 div_done;
  logic [MW-1:0]        div_dividend;
  logic [MW-1:0]        div_q;
  logic [SW-1:0]        sum_abs;

  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]        diff_abs;
  logic [31:0]              nz_wide;
  logic [31:0]              bytes_wide;
  logic [MAG_W-1:0]         q16;

  assign busy     = (state != S_LOAD);
  assign accept   = start && !busy;
  assign has_room = (count < CW'(MAX_SAMPLES));

  // Divider operands: |running sum| first, then the magnitude sum
  assign sum_abs      = run_sum[SW-1] ? SW'(-run_sum) : SW'(run_sum);
  assign div_start    = (state == S_DC_START) || (state == S_MEAN_START);
  assign div_dividend = (state == S_DC_START) ? MW'(sum_abs) : mag_sum;
  assign q16          = div_q[MAG_W-1:0];

  acls_div #(
    .DW (MW),
    .NW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sample buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      store[count[AW-1:0]] <= sample;
    end
    rdata <= store[rd_idx[AW-1:0]];
  end

  // Offset removal on read data
  assign diff     = {rdata[SAMPLE_W-1], rdata} - {dc[SAMPLE_W-1], dc};
  assign diff_abs = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);

  assign nz_wide    = 32'(nz);
  assign bytes_wide = 32'(count) << 1;

  // Control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      run_sum      <= '0;
      dropped      <= 1'b0;
      rd_idx       <= '0;
      rd_valid     <= 1'b0;
      mag_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      mag_valid    <= rd_valid;
      mag          <= diff_abs[MAG_W-1:0];

      // Accumulate the magnitude stage
      if (mag_valid) begin
        if (mag > peak) begin
          peak <= mag;
        end
        mag_sum <= mag_sum + MW'(mag);
        if (mag != '0) begin
          nz <= nz + 1'b1;
        end
      end

      case (state)
        S_LOAD: begin
          if (accept) begin
            if (has_room) begin
              count   <= count + 1'b1;
              run_sum <= run_sum + SW'(sample);
            end else begin
              dropped <= 1'b1;
            end
            if (last_sample) begin
              state <= S_DC_START;
            end
          end
        end
        S_DC_START: begin
          state <= S_DC_WAIT;
        end
        S_DC_WAIT: begin
          if (div_done) begin
            dc      <= run_sum[SW-1] ? sample_t'(-q16) : sample_t'(q16);
            peak    <= '0;
            mag_sum <= '0;
            nz      <= '0;
            rd_idx  <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx != count) begin
            rd_idx   <= rd_idx + 1'b1;
            rd_valid <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
            if (!rd_valid && !mag_valid) begin
              state <= S_MEAN_START;
            end
          end
        end
        S_MEAN_START: begin
          state <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_done) begin
            peak_magnitude <= peak;
            mean_magnitude <= q16;
            nonzero_count  <= nz_wide[NZ_W-1:0];
            byte_count     <= bytes_wide[BYTE_W-1:0];
            frame_offset   <= dc;
            overflow       <= dropped;
            result_valid   <= 1'b1;
            count          <= '0;
            run_sum        <= '0;
            dropped        <= 1'b0;
            state          <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Frame state is cleared when the result goes out
  a_clear_on_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (count == '0) && !dropped)
    else $error("frame state not cleared at result");

  // Stored count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES))
    else $error("stored count beyond capacity");

  // Divider completes only while a division is awaited
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DC_WAIT) || (state == S_MEAN_WAIT))
    else $error("divider done outside a wait state");

  // Buffer reads only during the scan
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == S_SCAN))
    else $error("buffer read outside scan");
`endif

endmodule
